// ===== sv/rsmm_pkg.sv =====
package rsmm_pkg;

  localparam int SIZE = 1024;
  localparam int POS_W = 10;
  localparam int NODE_W = POS_W + 1;
  localparam int DATA_W = 32;

  localparam logic signed [DATA_W-1:0] LEAST_INIT = 32'sd2147483647;
  localparam logic signed [DATA_W-1:0] GREATEST_INIT = -32'sd2147483647;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUM = 2'd1,
    OP_MIN = 2'd2,
    OP_MAX = 2'd3
  } op_t;

  // One node's three values, stored side by side in one memory word.
  typedef struct packed {
    logic [DATA_W-1:0]        total;
    logic signed [DATA_W-1:0] least;
    logic signed [DATA_W-1:0] greatest;
  } node_t;

endpackage

// ===== sv/rsmm_node_ram.sv =====
module rsmm_node_ram
  import rsmm_pkg::*;
(
  input  logic                clk,
  input  logic                wr_en,
  input  logic [NODE_W-1:0]   wr_addr,
  input  node_t               wr_data,
  input  logic [NODE_W-1:0]   rd_addr,
  output node_t               rd_data
);

  node_t mem [0:2*SIZE-1];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/range_sum_min_max_tree_core.sv =====
// Segment tree over 1024 positions holding a sum, minimum and maximum per node.
// The input channel (valid, ready) carries one word: op, position, amount,
// range_first and range_last. An add word (op 0) updates the eleven nodes from
// leaf to root and gives no output word. A query word (ops 1 to 3) gives one
// output word on (out_valid, out_ready) carrying answer.
// All nodes live in one memory with one write port and one registered read
// port (address, then registered data); a fold unit combines each query read.
// An add reads and then rewrites one node per level. A query walks the
// bottom-up tree with two cursors, up to two node reads per level, and then
// the output word is offered. After reset the block runs a clearing pass over
// all 2048 memory words, one node per cycle, writing the reset values; ready
// stays low during it.
// While an output word waits for out_ready the block accepts no new word.
module range_sum_min_max_tree_core
  import rsmm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     valid,
  output logic                     ready,
  input  logic [1:0]               op,
  input  logic [POS_W-1:0]         position,
  input  logic signed [DATA_W-1:0] amount,
  input  logic [POS_W-1:0]         range_first,
  input  logic [POS_W-1:0]         range_last,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] answer
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_ADD_RD, S_ADD_WR, S_Q_STEP, S_Q_WAIT, S_OUT
  } state_t;

  state_t state;
  op_t    q_op;
  logic [NODE_W:0]   l, r;       // one extra bit: r may reach 2*SIZE
  logic [NODE_W-1:0] n;
  logic [NODE_W-1:0] clr_cnt;
  logic signed [DATA_W-1:0] val;
  logic [DATA_W-1:0] acc;
  logic rd_left;                 // pending read came from the left cursor

  logic              wr_en;
  logic [NODE_W-1:0] wr_addr, rd_addr;
  node_t             wr_data, rd_data;

  rsmm_node_ram u_ram (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  // Fold unit: combine the read node with the running value.
  logic [DATA_W-1:0] fold;
  always_comb begin
    unique case (q_op)
      OP_SUM: fold = acc + rd_data.total;
      OP_MIN: fold = ($signed(rd_data.least) < $signed(acc)) ? rd_data.least : acc;
      OP_MAX: fold = ($signed(rd_data.greatest) > $signed(acc)) ? rd_data.greatest : acc;
      default: fold = acc;
    endcase
  end

  // Memory port control.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = n;
    wr_data.total    = rd_data.total + val;
    wr_data.least    = (val < rd_data.least) ? val : rd_data.least;
    wr_data.greatest = (val > rd_data.greatest) ? val : rd_data.greatest;
    rd_addr = n;
    if (state == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt;
      wr_data = '{total: '0, least: LEAST_INIT, greatest: GREATEST_INIT};
    end else if (state == S_ADD_WR) begin
      wr_en = 1'b1;
    end
    if (state == S_Q_STEP) begin
      rd_addr = l[0] ? l[NODE_W-1:0] : (r[NODE_W-1:0] - 1'b1);
    end
  end

  assign ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign answer = acc;

  logic [NODE_W:0] last_c;
  always_comb begin
    last_c = (range_last > POS_W'(SIZE - 1)) ? (NODE_W+1)'(SIZE - 1)
                                             : (NODE_W+1)'(range_last);
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == NODE_W'(2*SIZE-1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (valid) begin
            q_op <= op_t'(op);
            val  <= amount;
            n    <= NODE_W'(position) + NODE_W'(SIZE);
            l    <= (NODE_W+1)'(range_first) + (NODE_W+1)'(SIZE);
            r    <= last_c + (NODE_W+1)'(SIZE) + 1'b1;
            unique case (op_t'(op))
              OP_SUM: acc <= '0;
              OP_MIN: acc <= LEAST_INIT;
              default: acc <= GREATEST_INIT;
            endcase
            if (op_t'(op) == OP_ADD) begin
              state <= S_ADD_RD;
            end else if ((NODE_W+1)'(range_first) > last_c) begin
              state <= S_OUT;
            end else begin
              state <= S_Q_STEP;
            end
          end
        end
        S_ADD_RD: state <= S_ADD_WR;
        S_ADD_WR: begin
          n <= n >> 1;
          state <= (n == NODE_W'(1)) ? S_IDLE : S_ADD_RD;
        end
        S_Q_STEP: begin
          // Finish when the cursors meet, else issue a read for an odd cursor, or climb a level.
          if (l >= r) begin
            state <= S_OUT;
          end else if (l[0]) begin
            rd_left <= 1'b1;
            state <= S_Q_WAIT;
          end else if (r[0]) begin
            rd_left <= 1'b0;
            state <= S_Q_WAIT;
          end else begin
            l <= l >> 1;
            r <= r >> 1;
          end
        end
        S_Q_WAIT: begin
          acc <= fold;
          if (rd_left) l <= l + 1'b1;
          else r <= r - 1'b1;
          state <= S_Q_STEP;
        end
        S_OUT: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/sv/tb_range_sum_min_max_tree_core.sv =====
module tb_range_sum_min_max_tree_core;
  import rsmm_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic valid = 1'b0;
  logic ready;
  logic [1:0] op = OP_ADD;
  logic [POS_W-1:0] position = '0;
  logic signed [DATA_W-1:0] amount = '0;
  logic [POS_W-1:0] range_first = '0;
  logic [POS_W-1:0] range_last = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DATA_W-1:0] answer;

  // Shadow copy of the tree, kept as per-position leaf values plus leaf extremes.
  logic [DATA_W-1:0] leaf_total [SIZE];
  logic signed [DATA_W-1:0] leaf_least [SIZE];
  logic signed [DATA_W-1:0] leaf_greatest [SIZE];

  logic signed [DATA_W-1:0] pending_answers [$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_receiver = 1'b0;

  range_sum_min_max_tree_core uut (
    .clk(clk), .rst(rst), .valid(valid), .ready(ready), .op(op),
    .position(position), .amount(amount), .range_first(range_first),
    .range_last(range_last), .out_valid(out_valid), .out_ready(out_ready),
    .answer(answer)
  );

  always #4 clk = ~clk;

  // An interior node covers a contiguous span, so folding leaves gives the same answer.
  function automatic logic signed [DATA_W-1:0] range_answer(
      logic [1:0] code, logic [POS_W-1:0] lo_pos, logic [POS_W-1:0] hi_pos);
    logic [DATA_W-1:0] sum;
    logic signed [DATA_W-1:0] lo;
    logic signed [DATA_W-1:0] hi;
    int last_pos;
    sum = '0;
    lo = LEAST_INIT;
    hi = GREATEST_INIT;
    last_pos = hi_pos;
    if (last_pos > SIZE - 1) last_pos = SIZE - 1;
    for (int i = lo_pos; i <= last_pos; i++) begin
      sum += leaf_total[i];
      if (leaf_least[i] < lo) lo = leaf_least[i];
      if (leaf_greatest[i] > hi) hi = leaf_greatest[i];
    end
    case (code)
      OP_SUM: return sum;
      OP_MIN: return lo;
      default: return hi;
    endcase
  endfunction

  function automatic int gap_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one word and update the shadow tree once it is accepted.
  // Valid stays high into the next word when no gap follows.
  task automatic send_word(logic [1:0] code, logic [POS_W-1:0] pos,
      logic signed [DATA_W-1:0] val, logic [POS_W-1:0] lo_pos,
      logic [POS_W-1:0] hi_pos, bit gaps);
    int gap;
    gap = gaps ? gap_length() : 0;
    if (gap > 0) begin
      valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    valid <= 1'b1;
    op <= code;
    position <= pos;
    amount <= val;
    range_first <= lo_pos;
    range_last <= hi_pos;
    @(posedge clk);
    while (!ready) @(posedge clk);
    if (code == OP_ADD) begin
      leaf_total[pos] += val;
      if (val < leaf_least[pos]) leaf_least[pos] = val;
      if (val > leaf_greatest[pos]) leaf_greatest[pos] = val;
    end else begin
      pending_answers.push_back(range_answer(code, lo_pos, hi_pos));
    end
  endtask

  task automatic wait_drained();
    valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Empty tree, identities, reversed ranges and extreme values.
  task automatic test_directed();
    send_word(OP_SUM, 0, 0, 0, 1023, 0);
    send_word(OP_MIN, 0, 0, 0, 1023, 0);
    send_word(OP_MAX, 0, 0, 0, 1023, 0);
    send_word(OP_ADD, 0, 32'sh7fffffff, 0, 0, 0);
    send_word(OP_ADD, 1023, 32'sh80000000, 0, 0, 0);
    send_word(OP_ADD, 0, 32'sh7fffffff, 0, 0, 0);
    send_word(OP_ADD, 512, -1, 0, 0, 0);
    send_word(OP_ADD, 511, 5, 0, 0, 0);
    send_word(OP_SUM, 0, 0, 0, 1023, 0);
    send_word(OP_MIN, 0, 0, 0, 1023, 0);
    send_word(OP_MAX, 0, 0, 0, 1023, 0);
    send_word(OP_SUM, 0, 0, 0, 0, 0);
    send_word(OP_MIN, 0, 0, 1023, 1023, 0);
    send_word(OP_MAX, 0, 0, 511, 512, 0);
    send_word(OP_SUM, 0, 0, 5, 4, 0);
    send_word(OP_MIN, 0, 0, 1023, 0, 0);
    send_word(OP_MAX, 0, 0, 700, 3, 0);
    send_word(OP_SUM, 0, 0, 1, 1022, 0);
    send_word(OP_MAX, 0, 0, 1, 510, 0);
    send_word(OP_MIN, 0, 0, 513, 1022, 0);
    wait_drained();
  endtask

  // Random adds and queries with idling on both sides.
  task automatic test_random(int count);
    logic [POS_W-1:0] a;
    logic [POS_W-1:0] b;
    logic [DATA_W-1:0] val;
    for (int i = 0; i < count; i++) begin
      a = POS_W'($urandom);
      b = ($urandom_range(0, 3) == 0) ? POS_W'($urandom)
                                      : POS_W'(a + $urandom_range(0, 40));
      val = ($urandom_range(0, 1) == 0) ? $urandom : $signed($urandom_range(0, 200)) - 100;
      send_word(2'($urandom_range(0, 3)), POS_W'($urandom), val, a, b, 1);
    end
    wait_drained();
  endtask

  // Receiver holds off while the sender keeps offering queries.
  task automatic test_backpressure();
    hold_receiver = 1'b1;
    fork
      begin
        repeat (600) @(posedge clk);
        hold_receiver = 1'b0;
      end
      for (int i = 0; i < 8; i++)
        send_word(2'($urandom_range(1, 3)), 0, 0, POS_W'($urandom_range(0, 100)),
                  POS_W'($urandom), 0);
    join
    wait_drained();
  endtask

  // Receiver side: random stalls, check against the oldest expectation.
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected word, answer %0d", $time, answer);
        errors++;
      end else begin
        if (answer !== pending_answers[0]) begin
          $display("%0t: answer mismatch, expected %0d actual %0d",
                   $time, pending_answers[0], answer);
          errors++;
        end
        void'(pending_answers.pop_front());
      end
    end
    out_ready <= !hold_receiver && !rst && ($urandom_range(0, 9) < 7);
  end

  // Watchdog on cycles without any accepted word; allows for the clearing pass.
  always @(posedge clk) begin
    if ((valid && ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < SIZE; i++) begin
      leaf_total[i] = '0;
      leaf_least[i] = LEAST_INIT;
      leaf_greatest[i] = GREATEST_INIT;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_random(500);
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/rsmm_pkg.sv
sv/rsmm_node_ram.sv
sv/range_sum_min_max_tree_core.sv
tb/sv/tb_range_sum_min_max_tree_core.sv
